FILE: design/cqd_pkg.sv
// ----------------------------------------------------------------------------
// cqd_pkg
// Shared types, codes and the BCD helper for the Q-channel frame decoder.
// ----------------------------------------------------------------------------
package cqd_pkg;

  localparam logic [3:0] ModePosition = 4'h1;
  localparam logic [3:0] ModeCatalog  = 4'h2;
  localparam logic [3:0] ModeIsrc     = 4'h3;
  localparam logic [3:0] ModeFive     = 4'h5;

  localparam logic [7:0] TrackLeadOut   = 8'hAA;
  localparam logic [7:0] PointA0        = 8'hA0;
  localparam logic [7:0] PointA1        = 8'hA1;
  localparam logic [7:0] PointA2        = 8'hA2;
  localparam logic [7:0] PointB0        = 8'hB0;
  localparam logic [7:0] RelMinInvalid  = 8'hFF;
  localparam logic [7:0] LeadInMinLimit = 8'd90;
  localparam logic [1:0] AdrLowLeadIn   = 2'b01;

  localparam int unsigned FlagAny         = 0;
  localparam int unsigned FlagAbsTime     = 1;
  localparam int unsigned FlagCatalog     = 2;
  localparam int unsigned FlagIsrc        = 3;
  localparam int unsigned FlagFirstLeadIn = 4;
  localparam int unsigned FlagLeadIn      = 5;
  localparam int unsigned FlagProgram     = 6;
  localparam int unsigned FlagLeadOut     = 7;

  typedef struct packed {
    logic [7:0] control_address;
    logic [7:0] track;
    logic [7:0] index;
    logic [7:0] rel_min;
    logic [7:0] rel_sec;
    logic [7:0] rel_frame;
    logic [7:0] abs_min;
    logic [7:0] abs_sec;
    logic [7:0] abs_frame;
  } frame_t;

  typedef struct packed {
    logic [7:0] track;
    logic [7:0] index;
    logic [7:0] rel_min;
    logic [7:0] rel_sec;
    logic [7:0] rel_frame;
    logic [7:0] abs_min;
    logic [7:0] abs_sec;
    logic [7:0] abs_frame;
    logic [7:0] brake_minute;
    logic       brake_minute_valid;
    logic [7:0] area_flags;
  } result_t;

  function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = {4'b0000, b[7:4]};
    lo = {4'b0000, b[3:0]};
    return 8'({hi[4:0], 3'b000}) + 8'({hi[6:0], 1'b0}) + lo;
  endfunction

endpackage

FILE: design/cqd_field_conv.sv
// ----------------------------------------------------------------------------
// cqd_field_conv
// Mode-dependent BCD to binary conversion of the frame fields.
// ----------------------------------------------------------------------------
module cqd_field_conv (
  input  cqd_pkg::frame_t frame_i,
  output cqd_pkg::frame_t conv_o
);

  logic [3:0] mode;

  assign mode = frame_i.control_address[3:0];

  always_comb begin
    conv_o = frame_i;
    if (mode == cqd_pkg::ModePosition) begin
      if (frame_i.track != cqd_pkg::TrackLeadOut) begin
        conv_o.track = cqd_pkg::bcd_to_bin(frame_i.track);
      end
      conv_o.rel_min   = cqd_pkg::bcd_to_bin(frame_i.rel_min);
      conv_o.rel_sec   = cqd_pkg::bcd_to_bin(frame_i.rel_sec);
      conv_o.rel_frame = cqd_pkg::bcd_to_bin(frame_i.rel_frame);
      conv_o.abs_min   = cqd_pkg::bcd_to_bin(frame_i.abs_min);
      if (frame_i.index != cqd_pkg::PointA0 && frame_i.index != cqd_pkg::PointA1) begin
        conv_o.abs_sec   = cqd_pkg::bcd_to_bin(frame_i.abs_sec);
        conv_o.abs_frame = cqd_pkg::bcd_to_bin(frame_i.abs_frame);
        if (frame_i.index != cqd_pkg::PointA2) begin
          conv_o.index = cqd_pkg::bcd_to_bin(frame_i.index);
        end
      end
    end else if (mode == cqd_pkg::ModeFive) begin
      if (frame_i.track == 8'h00 && frame_i.index == cqd_pkg::PointB0 &&
          frame_i.rel_min != cqd_pkg::RelMinInvalid) begin
        conv_o.rel_min   = cqd_pkg::bcd_to_bin(frame_i.rel_min);
        conv_o.rel_sec   = cqd_pkg::bcd_to_bin(frame_i.rel_sec);
        conv_o.rel_frame = cqd_pkg::bcd_to_bin(frame_i.rel_frame);
      end
    end
  end

endmodule

FILE: design/cqd_area_flags.sv
// ----------------------------------------------------------------------------
// cqd_area_flags
// Brake minute and area-match flags from the converted frame.
// ----------------------------------------------------------------------------
module cqd_area_flags (
  input  cqd_pkg::frame_t conv_i,
  input  logic            disc_is_pressed_i,
  output cqd_pkg::result_t result_o
);

  logic [3:0] mode;
  logic       is_pos;
  logic       trk_zero;
  logic       trk_out;
  logic       lead_in_time;

  assign mode         = conv_i.control_address[3:0];
  assign is_pos       = (mode == cqd_pkg::ModePosition);
  assign trk_zero     = (conv_i.track == 8'h00);
  assign trk_out      = (conv_i.track == cqd_pkg::TrackLeadOut);
  assign lead_in_time = (conv_i.rel_min > cqd_pkg::LeadInMinLimit) || disc_is_pressed_i;

  always_comb begin
    result_o.track     = conv_i.track;
    result_o.index     = conv_i.index;
    result_o.rel_min   = conv_i.rel_min;
    result_o.rel_sec   = conv_i.rel_sec;
    result_o.rel_frame = conv_i.rel_frame;
    result_o.abs_min   = conv_i.abs_min;
    result_o.abs_sec   = conv_i.abs_sec;
    result_o.abs_frame = conv_i.abs_frame;

    result_o.brake_minute_valid = is_pos;
    result_o.brake_minute       = (is_pos && !trk_zero) ? conv_i.abs_min : 8'h00;

    result_o.area_flags                               = '0;
    result_o.area_flags[cqd_pkg::FlagAny]             = 1'b1;
    result_o.area_flags[cqd_pkg::FlagAbsTime]         = is_pos && (!trk_zero || !lead_in_time);
    result_o.area_flags[cqd_pkg::FlagCatalog]         = (mode == cqd_pkg::ModeCatalog);
    result_o.area_flags[cqd_pkg::FlagIsrc]            = (mode == cqd_pkg::ModeIsrc);
    result_o.area_flags[cqd_pkg::FlagFirstLeadIn]     = is_pos && trk_zero && lead_in_time;
    result_o.area_flags[cqd_pkg::FlagLeadIn]          =
      (conv_i.control_address[1:0] == cqd_pkg::AdrLowLeadIn) && trk_zero;
    result_o.area_flags[cqd_pkg::FlagProgram]         = is_pos && !trk_zero && !trk_out;
    result_o.area_flags[cqd_pkg::FlagLeadOut]         = is_pos && trk_out;
  end

endmodule

FILE: design/cd_q_subcode_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// cd_q_subcode_frame_decoder_top
// Q-channel subcode frame decoder: BCD to binary with area matching.
// ----------------------------------------------------------------------------
// One raw Q-channel frame is taken per transfer into an input register. The
// conversion and flag logic sits between that register and the result
// register. Each result is computed from the input register and registered
// in the result register; a result-side stall holds it back. A new frame is
// accepted every cycle while the result side keeps up. The user must write the
// pressed-disc bit via cfg_we_i/cfg_wdata_i while idle; the top does not check.
module cd_q_subcode_frame_decoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] control_address_i,
  input  logic [7:0] track_raw_i,
  input  logic [7:0] index_raw_i,
  input  logic [7:0] rel_min_raw_i,
  input  logic [7:0] rel_sec_raw_i,
  input  logic [7:0] rel_frame_raw_i,
  input  logic [7:0] abs_min_raw_i,
  input  logic [7:0] abs_sec_raw_i,
  input  logic [7:0] abs_frame_raw_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] track_out_o,
  output logic [7:0] index_out_o,
  output logic [7:0] rel_min_out_o,
  output logic [7:0] rel_sec_out_o,
  output logic [7:0] rel_frame_out_o,
  output logic [7:0] abs_min_out_o,
  output logic [7:0] abs_sec_out_o,
  output logic [7:0] abs_frame_out_o,
  output logic [7:0] brake_minute_o,
  output logic       brake_minute_valid_o,
  output logic [7:0] area_flags_o
);

  logic             pressed_q;
  logic             s1_valid_q;
  cqd_pkg::frame_t  s1_frame_q;
  logic             s2_valid_q;
  cqd_pkg::result_t s2_result_q;
  cqd_pkg::frame_t  conv;
  cqd_pkg::result_t result_d;
  logic             s2_ready;
  logic             s1_ready;

  assign s2_ready   = !s2_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q <= 1'b1;
    end else if (cfg_we_i) begin
      pressed_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_frame_q <= '{control_address: control_address_i,
                      track:           track_raw_i,
                      index:           index_raw_i,
                      rel_min:         rel_min_raw_i,
                      rel_sec:         rel_sec_raw_i,
                      rel_frame:       rel_frame_raw_i,
                      abs_min:         abs_min_raw_i,
                      abs_sec:         abs_sec_raw_i,
                      abs_frame:       abs_frame_raw_i};
    end
    if (s2_ready && s1_valid_q) begin
      s2_result_q <= result_d;
    end
  end

  cqd_field_conv u_conv (
    .frame_i (s1_frame_q),
    .conv_o  (conv)
  );

  cqd_area_flags u_flags (
    .conv_i            (conv),
    .disc_is_pressed_i (pressed_q),
    .result_o          (result_d)
  );

  assign out_valid_o          = s2_valid_q;
  assign track_out_o          = s2_result_q.track;
  assign index_out_o          = s2_result_q.index;
  assign rel_min_out_o        = s2_result_q.rel_min;
  assign rel_sec_out_o        = s2_result_q.rel_sec;
  assign rel_frame_out_o      = s2_result_q.rel_frame;
  assign abs_min_out_o        = s2_result_q.abs_min;
  assign abs_sec_out_o        = s2_result_q.abs_sec;
  assign abs_frame_out_o      = s2_result_q.abs_frame;
  assign brake_minute_o       = s2_result_q.brake_minute;
  assign brake_minute_valid_o = s2_result_q.brake_minute_valid;
  assign area_flags_o         = s2_result_q.area_flags;

endmodule

FILE: design/cqd_checker.sv
// ----------------------------------------------------------------------------
// cqd_checker
// Port-level assertions for the Q-channel frame decoder, bound to the top.
// ----------------------------------------------------------------------------
module cqd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] track_out_o,
  input logic [7:0] brake_minute_o,
  input logic       brake_minute_valid_o,
  input logic [7:0] area_flags_o
);

  // hold a stalled result transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(area_flags_o) &&
      $stable(track_out_o) && $stable(brake_minute_o))
    else $error("stalled result changed");

  a_any_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> area_flags_o[cqd_pkg::FlagAny])
    else $error("any-area flag clear");

  a_pos_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (brake_minute_valid_o ==
      (area_flags_o[cqd_pkg::FlagAbsTime] || area_flags_o[cqd_pkg::FlagFirstLeadIn])) &&
      !(area_flags_o[cqd_pkg::FlagAbsTime] && area_flags_o[cqd_pkg::FlagFirstLeadIn]))
    else $error("position-mode time flags inconsistent");

  a_brake_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (!brake_minute_valid_o || track_out_o == 8'h00) |->
      brake_minute_o == 8'h00)
    else $error("brake minute not zero");

  a_lead_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && area_flags_o[cqd_pkg::FlagLeadOut] |->
      track_out_o == cqd_pkg::TrackLeadOut && brake_minute_valid_o)
    else $error("lead-out flag without lead-out track");

endmodule

bind cd_q_subcode_frame_decoder_top cqd_checker u_cqd_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .out_valid_o          (out_valid_o),
  .out_ready_i          (out_ready_i),
  .track_out_o          (track_out_o),
  .brake_minute_o       (brake_minute_o),
  .brake_minute_valid_o (brake_minute_valid_o),
  .area_flags_o         (area_flags_o)
);

FILE: tb/cd_q_subcode_frame_decoder_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cd_q_subcode_frame_decoder_top_tb
// Self-checking bench for the Q-channel subcode frame decoder.
// ----------------------------------------------------------------------------
// Raw Q-channel frames are queued by a stimulus process and presented by a
// clocked driver. On each input transfer the bench decodes the frame itself
// (BCD conversion by address mode, brake minute, area flags) and queues the
// expected result. A clocked monitor compares every output transfer field by
// field with the oldest queued result. Both sides stall at random. The
// pressed-disc bit is rewritten between phases while the decoder is drained.
// ----------------------------------------------------------------------------
module cd_q_subcode_frame_decoder_top_tb;

  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned RandomPerPass = 450;

  logic       clk_i                = 1'b0;
  logic       rst_ni               = 1'b0;
  logic       cfg_we_i             = 1'b0;
  logic       cfg_wdata_i          = 1'b0;
  logic       in_valid_i           = 1'b0;
  logic       in_ready_o;
  logic [7:0] control_address_i    = 8'h00;
  logic [7:0] track_raw_i          = 8'h00;
  logic [7:0] index_raw_i          = 8'h00;
  logic [7:0] rel_min_raw_i        = 8'h00;
  logic [7:0] rel_sec_raw_i        = 8'h00;
  logic [7:0] rel_frame_raw_i      = 8'h00;
  logic [7:0] abs_min_raw_i        = 8'h00;
  logic [7:0] abs_sec_raw_i        = 8'h00;
  logic [7:0] abs_frame_raw_i      = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i          = 1'b0;
  logic [7:0] track_out_o;
  logic [7:0] index_out_o;
  logic [7:0] rel_min_out_o;
  logic [7:0] rel_sec_out_o;
  logic [7:0] rel_frame_out_o;
  logic [7:0] abs_min_out_o;
  logic [7:0] abs_sec_out_o;
  logic [7:0] abs_frame_out_o;
  logic [7:0] brake_minute_o;
  logic       brake_minute_valid_o;
  logic [7:0] area_flags_o;

  cqd_pkg::frame_t  frame_q[$];
  cqd_pkg::result_t decoded_q[$];
  logic        disc_pressed   = 1'b1;
  int unsigned cycle_cnt      = 0;
  int unsigned mismatch_cnt   = 0;
  int unsigned results_cnt    = 0;
  int unsigned position_cnt   = 0;
  int unsigned mode5_cnt      = 0;
  int unsigned other_cnt      = 0;
  int unsigned cfg_writes     = 0;
  logic        steady_stretch;

  cd_q_subcode_frame_decoder_top dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .control_address_i    (control_address_i),
    .track_raw_i          (track_raw_i),
    .index_raw_i          (index_raw_i),
    .rel_min_raw_i        (rel_min_raw_i),
    .rel_sec_raw_i        (rel_sec_raw_i),
    .rel_frame_raw_i      (rel_frame_raw_i),
    .abs_min_raw_i        (abs_min_raw_i),
    .abs_sec_raw_i        (abs_sec_raw_i),
    .abs_frame_raw_i      (abs_frame_raw_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .track_out_o          (track_out_o),
    .index_out_o          (index_out_o),
    .rel_min_out_o        (rel_min_out_o),
    .rel_sec_out_o        (rel_sec_out_o),
    .rel_frame_out_o      (rel_frame_out_o),
    .abs_min_out_o        (abs_min_out_o),
    .abs_sec_out_o        (abs_sec_out_o),
    .abs_frame_out_o      (abs_frame_out_o),
    .brake_minute_o       (brake_minute_o),
    .brake_minute_valid_o (brake_minute_valid_o),
    .area_flags_o         (area_flags_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  assign steady_stretch = (cycle_cnt >= 1200) && (cycle_cnt < 2000);

  function automatic logic [7:0] bcd_value(input logic [7:0] b);
    int unsigned v;
    v = b[7:4] * 10 + b[3:0];
    return v[7:0];
  endfunction

  function automatic logic [7:0] random_bcd();
    logic [3:0] hi;
    logic [3:0] lo;
    hi = 4'($urandom_range(0, 9));
    lo = 4'($urandom_range(0, 9));
    return {hi, lo};
  endfunction

  function automatic cqd_pkg::result_t decode_frame(input cqd_pkg::frame_t fr,
                                                    input logic pressed);
    cqd_pkg::result_t r;
    logic [3:0]       mode;
    logic [7:0]       tno;
    logic [7:0]       rmin;
    logic             lead_in_time;
    mode                 = fr.control_address[3:0];
    r.track              = fr.track;
    r.index              = fr.index;
    r.rel_min            = fr.rel_min;
    r.rel_sec            = fr.rel_sec;
    r.rel_frame          = fr.rel_frame;
    r.abs_min            = fr.abs_min;
    r.abs_sec            = fr.abs_sec;
    r.abs_frame          = fr.abs_frame;
    r.brake_minute       = 8'h00;
    r.brake_minute_valid = 1'b0;
    if (mode == cqd_pkg::ModePosition) begin
      if (fr.track != cqd_pkg::TrackLeadOut) begin
        r.track = bcd_value(fr.track);
      end
      r.rel_min   = bcd_value(fr.rel_min);
      r.rel_sec   = bcd_value(fr.rel_sec);
      r.rel_frame = bcd_value(fr.rel_frame);
      r.abs_min   = bcd_value(fr.abs_min);
      if (fr.index != cqd_pkg::PointA0 && fr.index != cqd_pkg::PointA1) begin
        r.abs_sec   = bcd_value(fr.abs_sec);
        r.abs_frame = bcd_value(fr.abs_frame);
        if (fr.index != cqd_pkg::PointA2) begin
          r.index = bcd_value(fr.index);
        end
      end
      r.brake_minute       = (r.track != 8'h00) ? r.abs_min : 8'h00;
      r.brake_minute_valid = 1'b1;
    end else if (mode == cqd_pkg::ModeFive) begin
      if (fr.track == 8'h00 && fr.index == cqd_pkg::PointB0 &&
          fr.rel_min != cqd_pkg::RelMinInvalid) begin
        r.rel_min   = bcd_value(fr.rel_min);
        r.rel_sec   = bcd_value(fr.rel_sec);
        r.rel_frame = bcd_value(fr.rel_frame);
      end
    end
    tno          = r.track;
    rmin         = r.rel_min;
    lead_in_time = (rmin > cqd_pkg::LeadInMinLimit) || pressed;
    r.area_flags                   = 8'h00;
    r.area_flags[cqd_pkg::FlagAny] = 1'b1;
    if (mode == cqd_pkg::ModePosition) begin
      r.area_flags[cqd_pkg::FlagAbsTime]     = (tno != 8'h00) || !lead_in_time;
      r.area_flags[cqd_pkg::FlagFirstLeadIn] = (tno == 8'h00) && lead_in_time;
      r.area_flags[cqd_pkg::FlagProgram]     =
        (tno != 8'h00) && (tno != cqd_pkg::TrackLeadOut);
      r.area_flags[cqd_pkg::FlagLeadOut]     = (tno == cqd_pkg::TrackLeadOut);
    end
    r.area_flags[cqd_pkg::FlagCatalog] = (mode == cqd_pkg::ModeCatalog);
    r.area_flags[cqd_pkg::FlagIsrc]    = (mode == cqd_pkg::ModeIsrc);
    r.area_flags[cqd_pkg::FlagLeadIn]  =
      (fr.control_address[1:0] == cqd_pkg::AdrLowLeadIn) && (tno == 8'h00);
    return r;
  endfunction

  function automatic cqd_pkg::frame_t random_frame();
    cqd_pkg::frame_t fr;
    int              pick;
    fr.control_address = 8'($urandom);
    fr.track           = 8'($urandom);
    fr.index           = 8'($urandom);
    fr.rel_min         = 8'($urandom);
    fr.rel_sec         = 8'($urandom);
    fr.rel_frame       = 8'($urandom);
    fr.abs_min         = 8'($urandom);
    fr.abs_sec         = 8'($urandom);
    fr.abs_frame       = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      fr.control_address[3:0] = cqd_pkg::ModePosition;
      case ($urandom_range(0, 9))
        0, 1:    fr.track = 8'h00;
        2:       fr.track = cqd_pkg::TrackLeadOut;
        3:       ;
        default: fr.track = random_bcd();
      endcase
      case ($urandom_range(0, 9))
        0:       fr.index = cqd_pkg::PointA0;
        1:       fr.index = cqd_pkg::PointA1;
        2:       fr.index = cqd_pkg::PointA2;
        3:       ;
        default: fr.index = random_bcd();
      endcase
      case ($urandom_range(0, 9))
        0:       fr.rel_min = 8'h89;
        1:       fr.rel_min = 8'h90;
        2:       fr.rel_min = 8'h91;
        3:       fr.rel_min = 8'h99;
        4:       ;
        default: fr.rel_min = random_bcd();
      endcase
      if ($urandom_range(0, 9) != 0) begin
        fr.rel_sec   = random_bcd();
        fr.rel_frame = random_bcd();
        fr.abs_min   = random_bcd();
        fr.abs_sec   = random_bcd();
        fr.abs_frame = random_bcd();
      end
    end else if (pick < 75) begin
      fr.control_address[3:0] = cqd_pkg::ModeFive;
      if ($urandom_range(0, 4) != 0) fr.track = 8'h00;
      if ($urandom_range(0, 4) != 0) fr.index = cqd_pkg::PointB0;
      if ($urandom_range(0, 3) == 0) begin
        fr.rel_min = cqd_pkg::RelMinInvalid;
      end else if ($urandom_range(0, 4) != 0) begin
        fr.rel_min = random_bcd();
      end
    end
    return fr;
  endfunction

  task automatic report_error(input string msg);
    mismatch_cnt++;
    $display("%0t: mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) begin
      report_error($sformatf("result %0d %s got %02h want %02h", results_cnt, name, got,
                             want));
    end
  endtask

  // Driver: hold the presented frame until its transfer, then present the next.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        case (frame_q[0].control_address[3:0])
          cqd_pkg::ModePosition: position_cnt++;
          cqd_pkg::ModeFive:     mode5_cnt++;
          default:               other_cnt++;
        endcase
        decoded_q.push_back(decode_frame(frame_q.pop_front(), disc_pressed));
      end
      if (!in_valid_i || in_ready_o) begin
        if (frame_q.size() > 0 && (steady_stretch || $urandom_range(0, 99) >= 22)) begin
          in_valid_i        <= 1'b1;
          control_address_i <= frame_q[0].control_address;
          track_raw_i       <= frame_q[0].track;
          index_raw_i       <= frame_q[0].index;
          rel_min_raw_i     <= frame_q[0].rel_min;
          rel_sec_raw_i     <= frame_q[0].rel_sec;
          rel_frame_raw_i   <= frame_q[0].rel_frame;
          abs_min_raw_i     <= frame_q[0].abs_min;
          abs_sec_raw_i     <= frame_q[0].abs_sec;
          abs_frame_raw_i   <= frame_q[0].abs_frame;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each output transfer with the oldest decoded frame.
  always @(posedge clk_i or negedge rst_ni) begin
    cqd_pkg::result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (decoded_q.size() == 0) begin
          report_error($sformatf("result %0d with no frame outstanding", results_cnt));
        end else begin
          want = decoded_q.pop_front();
          check_field("track", track_out_o, want.track);
          check_field("index", index_out_o, want.index);
          check_field("rel_min", rel_min_out_o, want.rel_min);
          check_field("rel_sec", rel_sec_out_o, want.rel_sec);
          check_field("rel_frame", rel_frame_out_o, want.rel_frame);
          check_field("abs_min", abs_min_out_o, want.abs_min);
          check_field("abs_sec", abs_sec_out_o, want.abs_sec);
          check_field("abs_frame", abs_frame_out_o, want.abs_frame);
          check_field("brake_minute", brake_minute_o, want.brake_minute);
          check_field("brake_minute_valid", {7'd0, brake_minute_valid_o},
                      {7'd0, want.brake_minute_valid});
          check_field("area_flags", area_flags_o, want.area_flags);
        end
        results_cnt++;
      end
      out_ready_i <= steady_stretch || ($urandom_range(0, 99) >= 22);
    end
  end

  task automatic wait_drained();
    while (frame_q.size() != 0 || decoded_q.size() != 0 || in_valid_i) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_pressed(input logic value);
    @(posedge clk_i);
    cfg_we_i     <= 1'b1;
    cfg_wdata_i  <= value;
    disc_pressed  = value;
    cfg_writes++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      frame_q.push_back(random_frame());
    end
  endtask

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
    end
    $display("[cd_q_subcode_frame_decoder_top] ERROR");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ca, track, index, rel m/s/f, abs m/s/f
    frame_q.push_back({8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    frame_q.push_back({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    frame_q.push_back({8'h01, 8'h12, 8'h01, 8'h03, 8'h45, 8'h67, 8'h12, 8'h34, 8'h56});
    frame_q.push_back({8'h41, 8'hAA, 8'h01, 8'h00, 8'h02, 8'h74, 8'h79, 8'h59, 8'h74});
    frame_q.push_back({8'h01, 8'h00, 8'hA0, 8'h00, 8'h10, 8'h20, 8'h01, 8'h20, 8'h00});
    frame_q.push_back({8'h01, 8'h00, 8'hA1, 8'h95, 8'h10, 8'h20, 8'h12, 8'h20, 8'h00});
    frame_q.push_back({8'h01, 8'h00, 8'hA2, 8'h91, 8'h10, 8'h20, 8'h45, 8'h33, 8'h22});
    frame_q.push_back({8'h01, 8'h00, 8'h05, 8'h90, 8'h59, 8'h74, 8'h00, 8'h00, 8'h00});
    frame_q.push_back({8'h01, 8'h00, 8'h05, 8'h89, 8'h00, 8'h00, 8'h99, 8'h99, 8'h99});
    frame_q.push_back({8'h01, 8'h00, 8'h05, 8'h91, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    frame_q.push_back({8'hF1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    frame_q.push_back({8'h01, 8'h99, 8'h99, 8'h99, 8'h99, 8'h99, 8'h99, 8'h99, 8'h99});
    frame_q.push_back({8'h02, 8'h12, 8'h34, 8'h56, 8'h78, 8'h90, 8'h12, 8'h34, 8'h56});
    frame_q.push_back({8'h03, 8'h00, 8'h34, 8'h56, 8'h78, 8'h90, 8'h12, 8'h34, 8'h56});
    frame_q.push_back({8'h05, 8'h00, 8'hB0, 8'h12, 8'h34, 8'h56, 8'h78, 8'h90, 8'h12});
    frame_q.push_back({8'h05, 8'h00, 8'hB0, 8'hFF, 8'h34, 8'h56, 8'h78, 8'h90, 8'h12});
    frame_q.push_back({8'h05, 8'h01, 8'hB0, 8'h12, 8'h34, 8'h56, 8'h78, 8'h90, 8'h12});
    frame_q.push_back({8'h05, 8'h00, 8'hB1, 8'h12, 8'h34, 8'h56, 8'h78, 8'h90, 8'h12});
    frame_q.push_back({8'h09, 8'h00, 8'h00, 8'h12, 8'h34, 8'h56, 8'h78, 8'h90, 8'h12});
    frame_q.push_back({8'h04, 8'h00, 8'h12, 8'h34, 8'h56, 8'h78, 8'h90, 8'h12, 8'h34});
    frame_q.push_back({8'h0D, 8'h00, 8'h12, 8'h34, 8'h56, 8'h78, 8'h90, 8'h12, 8'h34});
    frame_q.push_back({8'h01, 8'h00, 8'hFF, 8'hA0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    wait_drained();

    write_pressed(1'b0);
    queue_random(RandomPerPass);
    wait_drained();

    write_pressed(1'b1);
    queue_random(RandomPerPass);
    wait_drained();

    write_pressed(1'b0);
    queue_random(RandomPerPass);
    wait_drained();

    write_pressed(1'b1);
    queue_random(RandomPerPass);
    wait_drained();

    repeat (8) @(posedge clk_i);
    if (decoded_q.size() != 0) begin
      report_error($sformatf("%0d results never arrived", decoded_q.size()));
    end
    $display("decoded %0d frames: %0d position, %0d mode-5, %0d other modes",
             position_cnt + mode5_cnt + other_cnt, position_cnt, mode5_cnt, other_cnt);
    $display("%0d results compared, %0d pressed-disc writes, %0d mismatches",
             results_cnt, cfg_writes, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("[cd_q_subcode_frame_decoder_top] OK");
    end else begin
      $display("[cd_q_subcode_frame_decoder_top] ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/cqd_pkg.sv
design/cqd_field_conv.sv
design/cqd_area_flags.sv
design/cd_q_subcode_frame_decoder_top.sv
design/cqd_checker.sv
tb/cd_q_subcode_frame_decoder_top_tb.sv
